// ----- hw/rtl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// pss_pkg
// Shared constants, codes and control types of the PVT segment splitter.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Default largest number of subsegments one input may be split into.
    localparam int MAX_SUBSEGMENTS_DEF = 64;

    // Fixed point layout of the values and of the encoder scale factors.
    localparam int FRAC_BITS  = 16;
    localparam int SCALE_FRAC = 16;
    localparam int OUT_SHIFT  = FRAC_BITS + SCALE_FRAC;

    // Longest subsegment, in microseconds, and the time cap in milliseconds.
    localparam logic [23:0] SUB_LIMIT_US = 24'd255000;
    localparam int          US_PER_MS    = 1000;
    localparam int          TIME_CAP_MS  = 255;

    // Configuration register indexes.
    localparam logic [2:0] CFG_ANGLE_UPPER = 3'd0;
    localparam logic [2:0] CFG_ANGLE_LOWER = 3'd1;
    localparam logic [2:0] CFG_ANGLE_OFFS  = 3'd2;
    localparam logic [2:0] CFG_STEER_CPR   = 3'd3;
    localparam logic [2:0] CFG_WHEEL_CPM   = 3'd4;
    localparam logic [2:0] CFG_BACKWARDS   = 3'd5;

    // Configuration reset values.
    localparam logic signed [19:0] ANGLE_UPPER_RST = 20'sd205887;
    localparam logic signed [19:0] ANGLE_LOWER_RST = -20'sd205887;
    localparam logic signed [19:0] ANGLE_OFFS_RST  = 20'sd0;
    localparam logic [31:0]        STEER_CPR_RST   = 32'd65536;
    localparam logic [31:0]        WHEEL_CPM_RST   = 32'd65536;

    // Which quotient the shared divider is computing.
    typedef enum logic [2:0] {
        DIV_T_SHORT,
        DIV_COUNT,
        DIV_T_LONG,
        DIV_SHARE,
        DIV_ANGLE,
        DIV_RATE,
        DIV_SPEED
    } t_div_sel;

    // Operand pair of the shared scaling multiplier.
    typedef enum logic [1:0] {
        MUL_ANGLE,
        MUL_RATE,
        MUL_TRAVEL,
        MUL_SPEED
    } t_mul_sel;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_CLASS,
        S_TS,
        S_TS_W,
        S_N,
        S_N_W,
        S_TL,
        S_TL_W,
        S_SH,
        S_SH_W,
        S_A,
        S_A_W,
        S_R,
        S_R_W,
        S_V,
        S_V_W,
        S_PREP,
        S_MUL,
        S_WRITE
    } t_pss_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     latch_in;
        logic     seg_init;
        logic     div_start;
        t_div_sel div_sel;
        logic     prep;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     scale_en;
        t_mul_sel scale_sel;
        logic     out_load;
        logic     i_inc;
        logic     prev_update;
    } t_pss_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_short;
        logic div_done;
        logic last;
        logic out_free;
    } t_pss_sts;

endpackage

// ----- hw/rtl/pss_seg_if.sv -----
// ----------------------------------------------------------------------------
// pss_seg_if
// Input channel carrying one trajectory segment per transaction.
// ----------------------------------------------------------------------------
interface pss_seg_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] steering_angle;
    logic signed [23:0] steering_rate;
    logic signed [23:0] wheel_travel;
    logic signed [23:0] wheel_speed;
    logic [23:0]        duration_us;

    modport source (
        output valid, steering_angle, steering_rate, wheel_travel, wheel_speed,
               duration_us,
        input  ready
    );

    modport sink (
        input  valid, steering_angle, steering_rate, wheel_travel, wheel_speed,
               duration_us,
        output ready
    );
endinterface

// ----- hw/rtl/pss_pvt_if.sv -----
// ----------------------------------------------------------------------------
// pss_pvt_if
// Output channel carrying one servo PVT point per transaction.
// ----------------------------------------------------------------------------
interface pss_pvt_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] steer_position_counts;
    logic signed [31:0] steer_velocity_counts;
    logic signed [31:0] wheel_distance_counts;
    logic signed [31:0] wheel_velocity_counts;
    logic [7:0]         time_ms;
    logic               angle_clamped;
    logic               last_of_run;

    modport source (
        output valid, steer_position_counts, steer_velocity_counts,
               wheel_distance_counts, wheel_velocity_counts, time_ms,
               angle_clamped, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, steer_position_counts, steer_velocity_counts,
               wheel_distance_counts, wheel_velocity_counts, time_ms,
               angle_clamped, last_of_run,
        output ready
    );
endinterface

// ----- hw/rtl/pvt_segment_splitter_unit.sv -----
// ----------------------------------------------------------------------------
// pvt_segment_splitter_unit
// Splits trajectory segments into servo PVT points in encoder counts.
// ----------------------------------------------------------------------------
// A segment of at most 255 ms gives one point. A longer one is split into
// subsegments after setup, with three interpolations per subsegment through
// the bit-serial divider. One segment at a time: input ready is raised only in
// the idle state, entered once the last point is loaded, and a full output
// register stalls the sequencer.
// Synchronous active-low reset restores configuration, history and output.
module pvt_segment_splitter_unit #(
    parameter int MAX_SUBSEGMENTS = pss_pkg::MAX_SUBSEGMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    pss_seg_if.sink     i_seg,
    pss_pvt_if.source   o_pvt
);
    import pss_pkg::*;

    t_pss_cmd w_cmd;
    t_pss_sts w_sts;
    logic     w_in_ready;

    // Sequencer.
    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_seg.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    assign i_seg.ready = w_in_ready;

    // Arithmetic and output register.
    pss_datapath #(
        .MAX_SUBSEGMENTS (MAX_SUBSEGMENTS)
    ) u_datapath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (w_cmd),
        .o_sts                   (w_sts),
        .i_cfg_we                (i_cfg_we),
        .i_cfg_index             (i_cfg_index),
        .i_cfg_wdata             (i_cfg_wdata),
        .i_steering_angle        (i_seg.steering_angle),
        .i_steering_rate         (i_seg.steering_rate),
        .i_wheel_travel          (i_seg.wheel_travel),
        .i_wheel_speed           (i_seg.wheel_speed),
        .i_duration_us           (i_seg.duration_us),
        .i_out_ready             (o_pvt.ready),
        .o_out_valid             (o_pvt.valid),
        .o_steer_position_counts (o_pvt.steer_position_counts),
        .o_steer_velocity_counts (o_pvt.steer_velocity_counts),
        .o_wheel_distance_counts (o_pvt.wheel_distance_counts),
        .o_wheel_velocity_counts (o_pvt.wheel_velocity_counts),
        .o_time_ms               (o_pvt.time_ms),
        .o_angle_clamped         (o_pvt.angle_clamped),
        .o_last_of_run           (o_pvt.last_of_run)
    );
endmodule

// ----- hw/rtl/pss_div.sv -----
// ----------------------------------------------------------------------------
// pss_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pss_div #(
    parameter int DW = 35,
    parameter int VW = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);
    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [VW:0]   w_rem_sh;
    logic [VW:0]   w_diff;
    logic          w_ge;

    // One restoring step: shift in the next dividend bit and try to subtract.
    always_comb begin
        w_rem_sh = {r_rem, r_quo[DW-1]};
        w_diff   = w_rem_sh - {1'b0, r_div};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
    end

    // Step counter and done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CW'(DW);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift registers.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= w_ge ? w_diff[VW-1:0] : w_rem_sh[VW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

// ----- hw/rtl/pss_datapath.sv -----
// ----------------------------------------------------------------------------
// pss_datapath
// Registers, interpolation, clamping, scaling and the output register.
// ----------------------------------------------------------------------------
module pss_datapath #(
    parameter int MAX_SUBSEGMENTS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pss_pkg::t_pss_cmd  i_cmd,
    output pss_pkg::t_pss_sts  o_sts,
    // Configuration writes
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    // Input payload
    input  logic signed [19:0] i_steering_angle,
    input  logic signed [23:0] i_steering_rate,
    input  logic signed [23:0] i_wheel_travel,
    input  logic signed [23:0] i_wheel_speed,
    input  logic [23:0]        i_duration_us,
    // Output channel
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic signed [31:0] o_steer_position_counts,
    output logic signed [31:0] o_steer_velocity_counts,
    output logic signed [31:0] o_wheel_distance_counts,
    output logic signed [31:0] o_wheel_velocity_counts,
    output logic [7:0]         o_time_ms,
    output logic               o_angle_clamped,
    output logic               o_last_of_run
);
    import pss_pkg::*;

    localparam int IW  = $clog2(MAX_SUBSEGMENTS + 1);
    localparam int DW  = 26 + IW;
    localparam int VW  = (IW + 11 > 18) ? IW + 11 : 18;
    localparam int PW  = 63;

    // Constant divisors are handled by a reciprocal multiply and one correction step.
    localparam int          KW        = 25;
    localparam logic [22:0] RECIP_MS  = 23'((64'd1 << 32) / US_PER_MS);
    localparam logic [22:0] RECIP_SUB = 23'((64'd1 << 32) / SUB_LIMIT_US);

    // Configuration registers.
    logic signed [19:0] r_up, r_lo, r_off;
    logic [31:0]        r_cpr, r_cpm;
    logic               r_bw;

    // Segment, history and per-subsegment registers.
    logic signed [19:0] r_a, r_pa, r_ca;
    logic signed [23:0] r_r, r_pr, r_cr;
    logic signed [23:0] r_d, r_share;
    logic signed [23:0] r_v, r_pv, r_cv;
    logic [23:0]        r_dur;
    logic [IW-1:0]      r_n, r_i;
    logic [7:0]         r_t;
    t_div_sel           r_div_sel;
    logic               r_div_neg;

    // Prepared multiplier operands.
    logic signed [20:0] r_ang_adj;
    logic signed [27:0] r_rate10;
    logic signed [24:0] r_trav;
    logic signed [28:0] r_spd10;
    logic               r_clamp;

    logic signed [PW-1:0] r_prod;
    logic [31:0]          r_sp, r_sv, r_wd, r_wv;

    // Output register.
    logic               r_out_valid;
    logic [31:0]        r_o_sp, r_o_sv, r_o_wd, r_o_wv;
    logic [7:0]         r_o_t;
    logic               r_o_clamp, r_o_last;

    // Constant-divisor quotient registers.
    logic [KW-1:0]      r_kx;
    logic [7:0]         r_kq, r_kres;
    logic               r_kcount, r_kbusy, r_kdone;

    logic               w_is_short;
    logic signed [24:0] w_delta, w_abs;
    logic [23:0]        w_mag;
    logic               w_neg;
    logic [IW-1:0]      w_mult;
    logic [DW-1:0]      w_mi;
    logic [DW-1:0]      w_dividend;
    logic [VW-1:0]      w_divisor;
    logic               w_div_done;
    logic [DW-1:0]      w_q;
    logic               w_pdiv_start;
    logic               w_pdiv_done;
    logic [DW-1:0]      w_pdiv_q;
    logic               w_kconst;
    logic [22:0]        w_krecip;
    logic [47:0]        w_kprod;
    logic [17:0]        w_kden;
    logic [KW-1:0]      w_krem;
    logic [7:0]         w_kfix;
    logic signed [25:0] w_sq;
    logic signed [19:0] w_ang;
    logic               w_clamp;
    logic signed [24:0] w_trav, w_spd;
    logic signed [32:0] w_ma;
    logic signed [29:0] w_mb;
    logic [31:0]        w_scaled;

    // Rounded scaling to counts with saturation to 32 bits.
    function automatic logic [31:0] sat_round(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] q;
        logic [31:0]   res;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        q   = (mag + (PW'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (p[PW-1]) begin
            res = (q > PW'(64'd2147483648)) ? 32'h8000_0000 : 32'(-q);
        end else begin
            res = (q > PW'(64'd2147483647)) ? 32'h7FFF_FFFF : q[31:0];
        end
        return res;
    endfunction

    assign w_is_short = (r_dur <= SUB_LIMIT_US);

    // Signed difference, or the wheel travel for the share, feeding the rounded division.
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_SHARE: w_delta = 25'(r_d);
            DIV_ANGLE: w_delta = 25'(r_a) - 25'(r_pa);
            DIV_RATE:  w_delta = 25'(r_r) - 25'(r_pr);
            DIV_SPEED: w_delta = 25'(r_v) - 25'(r_pv);
            default:   w_delta = '0;
        endcase
        w_neg  = w_delta[24];
        w_abs  = w_neg ? -w_delta : w_delta;
        w_mag  = w_abs[23:0];
        w_mult = (i_cmd.div_sel == DIV_SHARE) ? IW'(1) : r_i;
        w_mi   = DW'(w_mag) * DW'(w_mult);
    end

    // Dividend and divisor of each quotient.
    always_comb begin
        unique case (i_cmd.div_sel)
            DIV_T_SHORT: begin
                w_dividend = DW'(r_dur) + DW'(US_PER_MS / 2);
                w_divisor  = VW'(US_PER_MS);
            end
            DIV_COUNT: begin
                w_dividend = DW'(r_dur) + DW'(SUB_LIMIT_US) - DW'(1);
                w_divisor  = VW'(SUB_LIMIT_US);
            end
            DIV_T_LONG: begin
                w_dividend = (DW'(r_dur) << 1) + DW'(VW'(r_n) * VW'(US_PER_MS));
                w_divisor  = VW'(r_n) * VW'(2 * US_PER_MS);
            end
            DIV_SHARE, DIV_ANGLE, DIV_RATE, DIV_SPEED: begin
                w_dividend = (w_mi << 1) + DW'(r_n);
                w_divisor  = VW'(r_n) << 1;
            end
            default: begin
                w_dividend = '0;
                w_divisor  = VW'(1);
            end
        endcase
    end

    // Divisions by a constant: the reciprocal estimate is at most one low,
    // so one compare against the remainder fixes it.
    always_comb begin
        w_kconst = (i_cmd.div_sel == DIV_T_SHORT) || (i_cmd.div_sel == DIV_COUNT);
        w_krecip = (i_cmd.div_sel == DIV_COUNT) ? RECIP_SUB : RECIP_MS;
        w_kprod  = 48'(w_dividend[KW-1:0]) * 48'(w_krecip);
        w_kden   = r_kcount ? 18'(SUB_LIMIT_US) : 18'(US_PER_MS);
        w_krem   = r_kx - KW'(r_kq) * KW'(w_kden);
        w_kfix   = (w_krem >= KW'(w_kden)) ? r_kq + 8'd1 : r_kq;
    end

    assign w_pdiv_start = i_cmd.div_start && !w_kconst;

    pss_div #(
        .DW (DW),
        .VW (VW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_pdiv_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_pdiv_done),
        .o_quotient (w_pdiv_q)
    );

    // Constant-divisor sequencing: estimate, correct, then a done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbusy <= 1'b0;
            r_kdone <= 1'b0;
        end else begin
            r_kbusy <= i_cmd.div_start && w_kconst;
            r_kdone <= r_kbusy;
        end
    end

    // Constant-divisor estimate and corrected quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && w_kconst) begin
            r_kx     <= w_dividend[KW-1:0];
            r_kq     <= w_kprod[39:32];
            r_kcount <= (i_cmd.div_sel == DIV_COUNT);
        end
        if (r_kbusy) begin
            r_kres <= w_kfix;
        end
    end

    assign w_div_done = w_pdiv_done || r_kdone;
    assign w_q        = r_kdone ? DW'(r_kres) : w_pdiv_q;

    // Signed rounded quotient.
    assign w_sq = r_div_neg ? -$signed(26'(w_q)) : $signed(26'(w_q));

    // Clamp, mounting direction and operand preparation.
    always_comb begin
        w_ang   = r_ca;
        w_clamp = 1'b0;
        if (w_ang > r_up) begin
            w_ang   = r_up;
            w_clamp = 1'b1;
        end
        if (w_ang < r_lo) begin
            w_ang   = r_lo;
            w_clamp = 1'b1;
        end
        w_trav = r_bw ? -25'(r_share) : 25'(r_share);
        w_spd  = r_bw ? -25'(r_cv) : 25'(r_cv);
    end

    // Multiplier operand selection.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_ANGLE:  w_mb = 30'(r_ang_adj);
            MUL_RATE:   w_mb = 30'(r_rate10);
            MUL_TRAVEL: w_mb = 30'(r_trav);
            MUL_SPEED:  w_mb = 30'(r_spd10);
            default:    w_mb = '0;
        endcase
        w_ma = (i_cmd.mul_sel == MUL_ANGLE || i_cmd.mul_sel == MUL_RATE) ?
               $signed({1'b0, r_cpr}) : $signed({1'b0, r_cpm});
    end

    assign w_scaled = sat_round(r_prod);

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up  <= ANGLE_UPPER_RST;
            r_lo  <= ANGLE_LOWER_RST;
            r_off <= ANGLE_OFFS_RST;
            r_cpr <= STEER_CPR_RST;
            r_cpm <= WHEEL_CPM_RST;
            r_bw  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ANGLE_UPPER: r_up  <= i_cfg_wdata[19:0];
                CFG_ANGLE_LOWER: r_lo  <= i_cfg_wdata[19:0];
                CFG_ANGLE_OFFS:  r_off <= i_cfg_wdata[19:0];
                CFG_STEER_CPR:   r_cpr <= i_cfg_wdata;
                CFG_WHEEL_CPM:   r_cpm <= i_cfg_wdata;
                CFG_BACKWARDS:   r_bw  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // History of the previous segment.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pa <= '0;
            r_pr <= '0;
            r_pv <= '0;
        end else if (i_cmd.prev_update) begin
            r_pa <= r_a;
            r_pr <= r_r;
            r_pv <= r_v;
        end
    end

    // Segment latch, quotient capture and operand preparation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_a   <= i_steering_angle;
            r_r   <= i_steering_rate;
            r_d   <= i_wheel_travel;
            r_v   <= i_wheel_speed;
            r_dur <= i_duration_us;
        end
        if (i_cmd.seg_init) begin
            r_i <= IW'(1);
            if (w_is_short) begin
                r_n     <= IW'(1);
                r_ca    <= r_a;
                r_cr    <= r_r;
                r_cv    <= r_v;
                r_share <= r_d;
            end
        end else if (i_cmd.i_inc) begin
            r_i <= r_i + 1'b1;
        end
        if (i_cmd.div_start) begin
            r_div_sel <= i_cmd.div_sel;
            r_div_neg <= w_neg;
        end
        if (w_div_done) begin
            unique case (r_div_sel)
                DIV_T_SHORT, DIV_T_LONG: begin
                    r_t <= (w_q > DW'(TIME_CAP_MS)) ? 8'(TIME_CAP_MS) : w_q[7:0];
                end
                DIV_COUNT: begin
                    r_n <= (w_q > DW'(MAX_SUBSEGMENTS)) ? IW'(MAX_SUBSEGMENTS) : IW'(w_q);
                end
                DIV_SHARE: r_share <= 24'(w_sq);
                DIV_ANGLE: r_ca    <= 20'(26'(r_pa) + w_sq);
                DIV_RATE:  r_cr    <= 24'(26'(r_pr) + w_sq);
                DIV_SPEED: r_cv    <= 24'(26'(r_pv) + w_sq);
                default: ;
            endcase
        end
        if (i_cmd.prep) begin
            r_ang_adj <= 21'(w_ang) - 21'(r_off);
            r_clamp   <= w_clamp;
            r_rate10  <= 28'(r_cr) * 28'sd10;
            r_trav    <= w_trav;
            r_spd10   <= 29'(w_spd) * 29'sd10;
        end
        if (i_cmd.mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.scale_en) begin
            unique case (i_cmd.scale_sel)
                MUL_ANGLE:  r_sp <= w_scaled;
                MUL_RATE:   r_sv <= w_scaled;
                MUL_TRAVEL: r_wd <= w_scaled;
                MUL_SPEED:  r_wv <= w_scaled;
                default: ;
            endcase
        end
    end

    // Output register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_sp    <= r_sp;
            r_o_sv    <= r_sv;
            r_o_wd    <= r_wd;
            r_o_wv    <= r_wv;
            r_o_t     <= r_t;
            r_o_clamp <= r_clamp;
            r_o_last  <= (r_i == r_n);
        end
    end

    assign o_sts.is_short = w_is_short;
    assign o_sts.div_done = w_div_done;
    assign o_sts.last     = (r_i == r_n);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid             = r_out_valid;
    assign o_steer_position_counts = r_o_sp;
    assign o_steer_velocity_counts = r_o_sv;
    assign o_wheel_distance_counts = r_o_wd;
    assign o_wheel_velocity_counts = r_o_wv;
    assign o_time_ms               = r_o_t;
    assign o_angle_clamped         = r_o_clamp;
    assign o_last_of_run           = r_o_last;
endmodule

// ----- hw/rtl/pss_ctrl.sv -----
// ----------------------------------------------------------------------------
// pss_ctrl
// Sequencer stepping the datapath through divisions, scaling and output.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  pss_pkg::t_pss_sts i_sts,
    output logic              o_in_ready,
    output pss_pkg::t_pss_cmd o_cmd
);
    import pss_pkg::*;

    t_pss_state r_state, n_state;
    logic [2:0] r_k, n_k;

    // State and multiply step registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        n_k        = r_k;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch_in = 1'b1;
                    n_state        = S_CLASS;
                end
            end
            S_CLASS: begin
                o_cmd.seg_init = 1'b1;
                n_state        = i_sts.is_short ? S_TS : S_N;
            end
            S_TS: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_T_SHORT;
                n_state         = S_TS_W;
            end
            S_TS_W: if (i_sts.div_done) n_state = S_PREP;
            S_N: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_COUNT;
                n_state         = S_N_W;
            end
            S_N_W: if (i_sts.div_done) n_state = S_TL;
            S_TL: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_T_LONG;
                n_state         = S_TL_W;
            end
            S_TL_W: if (i_sts.div_done) n_state = S_SH;
            S_SH: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SHARE;
                n_state         = S_SH_W;
            end
            S_SH_W: if (i_sts.div_done) n_state = S_A;
            S_A: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_ANGLE;
                n_state         = S_A_W;
            end
            S_A_W: if (i_sts.div_done) n_state = S_R;
            S_R: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_RATE;
                n_state         = S_R_W;
            end
            S_R_W: if (i_sts.div_done) n_state = S_V;
            S_V: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_SPEED;
                n_state         = S_V_W;
            end
            S_V_W: if (i_sts.div_done) n_state = S_PREP;
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_k        = '0;
                n_state    = S_MUL;
            end
            // Four products through one multiplier; each is registered, then scaled from the product register.
            S_MUL: begin
                o_cmd.mul_en    = (r_k != 3'd4);
                o_cmd.mul_sel   = t_mul_sel'(r_k[1:0]);
                o_cmd.scale_en  = (r_k != 3'd0);
                o_cmd.scale_sel = t_mul_sel'(r_k[1:0] - 2'd1);
                n_k             = r_k + 1'b1;
                if (r_k == 3'd4) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.last) begin
                        o_cmd.prev_update = 1'b1;
                        n_state           = S_IDLE;
                    end else begin
                        o_cmd.i_inc = 1'b1;
                        n_state     = S_A;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- bench/pvt_segment_splitter_unit_tb.sv -----
// ----------------------------------------------------------------------------
// pvt_segment_splitter_unit_tb
// Self-checking bench: directed and random segments are driven under random
// idling on both channels. Each accepted segment is run through a local
// PVT predictor, and every output transaction is compared field by field.
// ----------------------------------------------------------------------------
module pvt_segment_splitter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pss_pkg::*;

    typedef struct packed {
        logic signed [19:0] angle;
        logic signed [23:0] rate;
        logic signed [23:0] travel;
        logic signed [23:0] speed;
        logic [23:0]        dur;
    } seg_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] wdist;
        logic signed [31:0] wvel;
        logic [7:0]         tms;
        logic               clamped;
        logic               last;
    } point_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    pss_seg_if seg_ch ();
    pss_pvt_if pvt_ch ();

    pvt_segment_splitter_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata),
        .i_seg      (seg_ch.sink),
        .o_pvt      (pvt_ch.source)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Predictor copy of configuration and stored previous segment.
    logic signed [19:0] m_upper = ANGLE_UPPER_RST;
    logic signed [19:0] m_lower = ANGLE_LOWER_RST;
    logic signed [19:0] m_offs  = ANGLE_OFFS_RST;
    logic [31:0]        m_cpr   = STEER_CPR_RST;
    logic [31:0]        m_cpm   = WHEEL_CPM_RST;
    logic               m_back  = 1'b0;
    logic signed [19:0] p_angle = '0;
    logic signed [23:0] p_rate  = '0;
    logic signed [23:0] p_speed = '0;

    seg_t   pending_segs[$];
    point_t expected_points[$];
    int     send_idle_pct = 10;
    int     recv_idle_pct = 74;
    int     errors = 0;
    longint cycles = 0;

    function automatic longint div_half_away(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    // Drop OUT_SHIFT fraction bits, round half away, saturate to 32 bits.
    function automatic logic [31:0] to_counts(logic signed [95:0] p);
        logic [95:0] mag;
        logic [95:0] q;
        mag = (p < 0) ? -p : p;
        q = (mag + (96'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (p < 0)
            return (q > 96'h8000_0000) ? 32'h8000_0000 : -q[31:0];
        return (q > 96'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    function automatic point_t make_point(longint angle, longint rate, longint travel,
                                          longint speed, logic [7:0] tms, logic last);
        point_t pt;
        logic signed [95:0] cpr;
        logic signed [95:0] cpm;
        cpr = {64'd0, m_cpr};
        cpm = {64'd0, m_cpm};
        pt.clamped = 1'b0;
        if (m_back) begin
            travel = -travel;
            speed = -speed;
        end
        if (angle > m_upper) begin
            angle = m_upper;
            pt.clamped = 1'b1;
        end
        if (angle < m_lower) begin
            angle = m_lower;
            pt.clamped = 1'b1;
        end
        angle = angle - m_offs;
        pt.pos   = to_counts(cpr * 96'(signed'(angle)));
        pt.vel   = to_counts(cpr * 10 * 96'(signed'(rate)));
        pt.wdist = to_counts(cpm * 96'(signed'(travel)));
        pt.wvel  = to_counts(cpm * 10 * 96'(signed'(speed)));
        pt.tms   = tms;
        pt.last  = last;
        return pt;
    endfunction

    // Split one accepted segment into its expected PVT points.
    task automatic predict_points(seg_t s);
        longint n;
        longint t;
        longint share;
        if (s.dur <= SUB_LIMIT_US) begin
            t = (longint'(s.dur) + 500) / US_PER_MS;
            if (t > TIME_CAP_MS) t = TIME_CAP_MS;
            expected_points.push_back(make_point(s.angle, s.rate, s.travel, s.speed,
                                                 t[7:0], 1'b1));
        end else begin
            n = (longint'(s.dur) + SUB_LIMIT_US - 1) / SUB_LIMIT_US;
            if (n > MAX_SUBSEGMENTS_DEF) n = MAX_SUBSEGMENTS_DEF;
            t = (2 * longint'(s.dur) + n * 1000) / (2 * n * 1000);
            if (t > TIME_CAP_MS) t = TIME_CAP_MS;
            share = div_half_away(s.travel, n);
            for (longint i = 1; i <= n; i++)
                expected_points.push_back(make_point(
                    p_angle + div_half_away((s.angle - p_angle) * i, n),
                    p_rate + div_half_away((s.rate - p_rate) * i, n),
                    share,
                    p_speed + div_half_away((s.speed - p_speed) * i, n),
                    t[7:0], i == n));
        end
        p_angle = s.angle;
        p_rate  = s.rate;
        p_speed = s.speed;
    endtask

    // Driver: present queued segments at the falling edge.
    initial begin
        seg_ch.valid = 1'b0;
        seg_ch.steering_angle = '0;
        seg_ch.steering_rate = '0;
        seg_ch.wheel_travel = '0;
        seg_ch.wheel_speed = '0;
        seg_ch.duration_us = '0;
        pvt_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!seg_ch.valid || seg_ch.ready) begin
            if (pending_segs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                seg_t s;
                s = pending_segs.pop_front();
                seg_ch.valid <= 1'b1;
                seg_ch.steering_angle <= s.angle;
                seg_ch.steering_rate <= s.rate;
                seg_ch.wheel_travel <= s.travel;
                seg_ch.wheel_speed <= s.speed;
                seg_ch.duration_us <= s.dur;
            end else begin
                seg_ch.valid <= 1'b0;
            end
        end
        pvt_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predict on input transactions, check output transactions.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && seg_ch.valid && seg_ch.ready)
            predict_points({seg_ch.steering_angle, seg_ch.steering_rate,
                            seg_ch.wheel_travel, seg_ch.wheel_speed,
                            seg_ch.duration_us});
        if (i_rst_n && pvt_ch.valid && pvt_ch.ready) begin
            point_t got;
            point_t want;
            got = {pvt_ch.steer_position_counts, pvt_ch.steer_velocity_counts,
                   pvt_ch.wheel_distance_counts, pvt_ch.wheel_velocity_counts,
                   pvt_ch.time_ms, pvt_ch.angle_clamped, pvt_ch.last_of_run};
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected point %p", $realtime, got);
                errors++;
            end else begin
                want = expected_points.pop_front();
                if (got.pos != want.pos || got.vel != want.vel || got.wdist != want.wdist ||
                    got.wvel != want.wvel || got.tms != want.tms ||
                    got.clamped != want.clamped || got.last != want.last) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ANGLE_UPPER: m_upper = val[19:0];
            CFG_ANGLE_LOWER: m_lower = val[19:0];
            CFG_ANGLE_OFFS:  m_offs = val[19:0];
            CFG_STEER_CPR:   m_cpr = val;
            CFG_WHEEL_CPM:   m_cpm = val;
            CFG_BACKWARDS:   m_back = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_segs.size() != 0 || seg_ch.valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    function automatic seg_t rand_seg();
        seg_t s;
        s.angle = $urandom;
        s.rate = $urandom;
        s.travel = $urandom;
        s.speed = $urandom;
        case ($urandom_range(9))
            0, 1, 2, 3: s.dur = $urandom_range(255000);
            4, 5, 6:    s.dur = $urandom_range(1400000, 255001);
            7:          s.dur = $urandom_range(1000) + 254500;
            8:          s.dur = $urandom_range(16320000, 255001);
            default:    s.dur = $urandom & 24'hFFFFFF;
        endcase
        if ($urandom_range(3) == 0) s.angle = $urandom_range(400000) - 200000;
        return s;
    endfunction

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycles > 10000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, splitting boundary, clamp boundary, zero duration.
        pending_segs.push_back('{20'sh7FFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'd0});
        pending_segs.push_back('{20'sh80000, 24'sh800000, 24'sh800000, 24'sh800000,
                                 24'd255000});
        pending_segs.push_back('{20'sd1000, 24'sd500, -24'sd3, 24'sd7, 24'd255001});
        pending_segs.push_back('{-20'sd1000, -24'sd500, 24'sd3, -24'sd7, 24'd16320000});
        pending_segs.push_back('{20'sd0, 24'sd0, 24'sd0, 24'sd0, 24'hFFFFFF});
        pending_segs.push_back('{20'sd205887, 24'sd65536, 24'sd65536, 24'sd65536,
                                 24'd499});
        pending_segs.push_back('{20'sd205888, 24'sd1, 24'sd1, 24'sd1, 24'd500});
        wait_drained();

        write_reg(CFG_STEER_CPR, 32'hFFFF_FFFF);
        write_reg(CFG_WHEEL_CPM, 32'hFFFF_FFFF);
        write_reg(CFG_BACKWARDS, 32'd1);
        write_reg(CFG_ANGLE_UPPER, 32'h0007_FFFF);
        write_reg(CFG_ANGLE_LOWER, 32'h0008_0000);
        write_reg(CFG_ANGLE_OFFS, 32'h0008_0000);
        pending_segs.push_back('{20'sh7FFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'd100});
        pending_segs.push_back('{20'sh80000, 24'sh800000, 24'sh800000, 24'sh800000,
                                 24'd600000});
        wait_drained();

        // Crossed limits: lower above upper.
        write_reg(CFG_ANGLE_UPPER, -32'sd1000);
        write_reg(CFG_ANGLE_LOWER, 32'd1000);
        write_reg(CFG_ANGLE_OFFS, 32'h0007_FFFF);
        write_reg(CFG_STEER_CPR, 32'd0);
        write_reg(CFG_WHEEL_CPM, 32'd0);
        pending_segs.push_back('{20'sd0, 24'sd5, 24'sd5, 24'sd5, 24'd1000});
        pending_segs.push_back('{20'sd5000, 24'sd5, 24'sd5, 24'sd5, 24'd700000});
        wait_drained();

        // Random phases with varied settings and idling.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 10 : (ph == 1) ? 74 : 0;
            recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 10 : 0;
            write_reg(CFG_ANGLE_UPPER, $urandom_range(300000));
            write_reg(CFG_ANGLE_LOWER, -$urandom_range(300000));
            write_reg(CFG_ANGLE_OFFS, $urandom & 32'hFFFFF);
            write_reg(CFG_STEER_CPR, (ph == 2) ? $urandom : $urandom_range(2000000));
            write_reg(CFG_WHEEL_CPM, (ph == 2) ? $urandom : $urandom_range(2000000));
            write_reg(CFG_BACKWARDS, 32'(ph[0]));
            for (int k = 0; k < 60; k++)
                pending_segs.push_back(rand_seg());
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ----- files.f -----
hw/rtl/pss_pkg.sv
hw/rtl/pss_seg_if.sv
hw/rtl/pss_pvt_if.sv
hw/rtl/pss_div.sv
hw/rtl/pss_datapath.sv
hw/rtl/pss_ctrl.sv
hw/rtl/pvt_segment_splitter_unit.sv
bench/pvt_segment_splitter_unit_tb.sv
